// ===== design/slle_pkg.sv =====
`default_nettype none

package slle_pkg;

   localparam int NODES_DEFAULT = 128;
   localparam int CMD_W         = 2;
   localparam int POS_W         = 7;
   localparam int VAL_W         = 32;
   localparam int STATUS_W      = 2;
   localparam int IDX_OUT_W     = 7;
   localparam int LEN_W         = 7;

   typedef enum logic [CMD_W-1:0] {
      CMD_INSERT = 2'd0,
      CMD_DELETE = 2'd1,
      CMD_LOCATE = 2'd2,
      CMD_LENGTH = 2'd3
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_RANGE = 2'd1,
      ST_FULL  = 2'd2,
      ST_MISS  = 2'd3
   } status_type;

   // link ram read address source
   typedef enum logic [2:0] {
      LRA_ZERO,
      LRA_HEAD,
      LRA_AT,
      LRA_NODE,
      LRA_RD
   } lra_type;

   // link ram write address source
   typedef enum logic [1:0] {
      LWA_CLR,
      LWA_ZERO,
      LWA_AT,
      LWA_NODE
   } lwa_type;

   // link ram write data source
   typedef enum logic [1:0] {
      LWD_CLR,
      LWD_RD,
      LWD_NODE
   } lwd_type;

   typedef enum logic {
      AT_HEAD,
      AT_RD
   } at_src_type;

   typedef enum logic {
      STEPS_POS,
      STEPS_COUNT
   } steps_src_type;

   typedef struct packed {
      logic          clr_step;
      lra_type       link_rsel;
      logic          link_we;
      lwa_type       link_wsel;
      lwd_type       link_dsel;
      logic          val_we;
      logic          req_take;
      logic          at_load;
      at_src_type    at_sel;
      logic          node_load;
      logic          steps_load;
      steps_src_type steps_sel;
      logic          steps_dec;
      logic          count_inc;
      logic          count_dec;
      logic          res_load;
      status_type    res_status;
      logic          res_found;
      logic          rsp_load;
   } ctrl_cmd_type;

   typedef struct packed {
      cmd_type cmd_code;
      logic    clr_last;
      logic    ins_bad;
      logic    del_bad;
      logic    rd_zero;
      logic    steps_zero;
      logic    steps_one;
      logic    val_match;
      logic    rsp_busy;
   } dp_status_type;

   localparam ctrl_cmd_type CTRL_NOP = '{
      clr_step:   1'b0,
      link_rsel:  LRA_ZERO,
      link_we:    1'b0,
      link_wsel:  LWA_ZERO,
      link_dsel:  LWD_RD,
      val_we:     1'b0,
      req_take:   1'b0,
      at_load:    1'b0,
      at_sel:     AT_HEAD,
      node_load:  1'b0,
      steps_load: 1'b0,
      steps_sel:  STEPS_POS,
      steps_dec:  1'b0,
      count_inc:  1'b0,
      count_dec:  1'b0,
      res_load:   1'b0,
      res_status: ST_OK,
      res_found:  1'b0,
      rsp_load:   1'b0
   };

endpackage

`default_nettype wire

// ===== design/slle_ram.sv =====
`default_nettype none

module slle_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

// ===== design/slle_dp.sv =====
`default_nettype none

module slle_dp #(
   parameter int NODES = slle_pkg::NODES_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic [slle_pkg::CMD_W-1:0]          req_cmd,
   input  wire logic [slle_pkg::POS_W-1:0]          req_position,
   input  wire logic signed [slle_pkg::VAL_W-1:0]   req_value,
   input  wire slle_pkg::ctrl_cmd_type              cmd,
   output slle_pkg::dp_status_type                  stat,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic [slle_pkg::STATUS_W-1:0]            rsp_status,
   output logic [slle_pkg::IDX_OUT_W-1:0]           rsp_node_index,
   output logic [slle_pkg::LEN_W-1:0]               rsp_list_length
);

   localparam int IW   = $clog2(NODES);
   localparam int CMPW = ((IW > slle_pkg::POS_W) ? IW : slle_pkg::POS_W) + 1;

   slle_pkg::cmd_type             cmd_ff;
   logic [slle_pkg::POS_W-1:0]    pos_ff;
   logic [slle_pkg::VAL_W-1:0]    val_ff;
   logic [IW-1:0]                 count_ff;
   logic [IW-1:0]                 at_ff;
   logic [IW-1:0]                 node_ff;
   logic [IW-1:0]                 steps_ff;
   logic [IW-1:0]                 clr_ff;
   slle_pkg::status_type          res_status_ff;
   logic [IW-1:0]                 res_found_ff;
   logic                          rsp_valid_ff;
   logic [slle_pkg::STATUS_W-1:0] rsp_status_ff;
   logic [slle_pkg::IDX_OUT_W-1:0] rsp_index_ff;
   logic [slle_pkg::LEN_W-1:0]    rsp_length_ff;

   logic [IW-1:0]                 link_raddr;
   logic [IW-1:0]                 link_rdata;
   logic [IW-1:0]                 link_waddr;
   logic [IW-1:0]                 link_wdata;
   logic [IW-1:0]                 clr_data;
   logic [slle_pkg::VAL_W-1:0]    val_rdata;
   logic [CMPW-1:0]               pos_w;
   logic [CMPW-1:0]               count_w;
   logic [CMPW-1:0]               pos_m1;
   logic [CMPW-1:0]               found_w;

   localparam logic [IW-1:0] HEAD = IW'(NODES - 1);

   // free chain 1..NODES-2, last two entries end their chains
   assign clr_data = (int'(clr_ff) < NODES - 2) ? clr_ff + IW'(1) : '0;

   always_comb begin
      case (cmd.link_rsel)
         slle_pkg::LRA_ZERO: link_raddr = '0;
         slle_pkg::LRA_HEAD: link_raddr = HEAD;
         slle_pkg::LRA_AT:   link_raddr = at_ff;
         slle_pkg::LRA_NODE: link_raddr = node_ff;
         slle_pkg::LRA_RD:   link_raddr = link_rdata;
         default:            link_raddr = '0;
      endcase
      case (cmd.link_wsel)
         slle_pkg::LWA_CLR:  link_waddr = clr_ff;
         slle_pkg::LWA_ZERO: link_waddr = '0;
         slle_pkg::LWA_AT:   link_waddr = at_ff;
         slle_pkg::LWA_NODE: link_waddr = node_ff;
         default:            link_waddr = '0;
      endcase
      case (cmd.link_dsel)
         slle_pkg::LWD_CLR:  link_wdata = clr_data;
         slle_pkg::LWD_RD:   link_wdata = link_rdata;
         slle_pkg::LWD_NODE: link_wdata = node_ff;
         default:            link_wdata = '0;
      endcase
   end

   slle_ram #(
      .WIDTH (IW),
      .DEPTH (NODES)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (cmd.link_we),
      .wr_addr (link_waddr),
      .wr_data (link_wdata),
      .rd_addr (link_raddr),
      .rd_data (link_rdata)
   );

   // written at the node just popped, whose index is on the link read port
   slle_ram #(
      .WIDTH (slle_pkg::VAL_W),
      .DEPTH (NODES)
   ) u_value_ram (
      .clock   (clock),
      .wr_en   (cmd.val_we),
      .wr_addr (link_rdata),
      .wr_data (val_ff),
      .rd_addr (link_raddr),
      .rd_data (val_rdata)
   );

   assign pos_w   = CMPW'(pos_ff);
   assign count_w = CMPW'(count_ff);
   assign pos_m1  = pos_w - CMPW'(1);
   assign found_w = CMPW'(res_found_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.clr_step) begin
            clr_ff <= clr_ff + IW'(1);
         end
         if (cmd.count_inc) begin
            count_ff <= count_ff + IW'(1);
         end else if (cmd.count_dec) begin
            count_ff <= count_ff - IW'(1);
         end
         if (cmd.rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.req_take) begin
         cmd_ff <= slle_pkg::cmd_type'(req_cmd);
         pos_ff <= req_position;
         val_ff <= req_value;
      end
      if (cmd.at_load) begin
         at_ff <= (cmd.at_sel == slle_pkg::AT_HEAD) ? HEAD : link_rdata;
      end
      if (cmd.node_load) begin
         node_ff <= link_rdata;
      end
      if (cmd.steps_load) begin
         steps_ff <= (cmd.steps_sel == slle_pkg::STEPS_POS) ? pos_m1[IW-1:0] : count_ff;
      end else if (cmd.steps_dec) begin
         steps_ff <= steps_ff - IW'(1);
      end
      if (cmd.res_load) begin
         res_status_ff <= cmd.res_status;
         res_found_ff  <= cmd.res_found ? at_ff : '0;
      end
      if (cmd.rsp_load) begin
         rsp_status_ff <= res_status_ff;
         rsp_index_ff  <= found_w[slle_pkg::IDX_OUT_W-1:0];
         rsp_length_ff <= count_w[slle_pkg::LEN_W-1:0];
      end
   end

   always_comb begin
      stat.cmd_code   = cmd_ff;
      stat.clr_last   = (clr_ff == HEAD);
      stat.ins_bad    = (pos_ff == '0) || (pos_w > count_w + CMPW'(1));
      stat.del_bad    = (pos_ff == '0) || (pos_w > count_w);
      stat.rd_zero    = (link_rdata == '0);
      stat.steps_zero = (steps_ff == '0);
      stat.steps_one  = (steps_ff == IW'(1));
      stat.val_match  = (val_rdata == val_ff);
      stat.rsp_busy   = rsp_valid_ff && !rsp_ready;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_node_index  = rsp_index_ff;
   assign rsp_list_length = rsp_length_ff;

endmodule

`default_nettype wire

// ===== design/slle_ctrl.sv =====
`default_nettype none

module slle_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire slle_pkg::dp_status_type stat,
   output slle_pkg::ctrl_cmd_type       cmd
);

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_DECODE,
      S_INS_FRESH,
      S_INS_POP,
      S_WALK,
      S_WALK_STEP,
      S_PRED,
      S_INS_LINK,
      S_DEL_GONE,
      S_DEL_FREE,
      S_DEL_PUSH,
      S_LOC_NEXT,
      S_LOC_CMP,
      S_DONE
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      cmd      = slle_pkg::CTRL_NOP;
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: begin
            cmd.clr_step  = 1'b1;
            cmd.link_we   = 1'b1;
            cmd.link_wsel = slle_pkg::LWA_CLR;
            cmd.link_dsel = slle_pkg::LWD_CLR;
            if (stat.clr_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.req_take = 1'b1;
               state_in     = S_DECODE;
            end
         end
         S_DECODE: begin
            case (stat.cmd_code)
               slle_pkg::CMD_INSERT: begin
                  if (stat.ins_bad) begin
                     cmd.res_load   = 1'b1;
                     cmd.res_status = slle_pkg::ST_RANGE;
                     state_in       = S_DONE;
                  end else begin
                     cmd.link_rsel = slle_pkg::LRA_ZERO;
                     state_in      = S_INS_FRESH;
                  end
               end
               slle_pkg::CMD_DELETE: begin
                  if (stat.del_bad) begin
                     cmd.res_load   = 1'b1;
                     cmd.res_status = slle_pkg::ST_RANGE;
                     state_in       = S_DONE;
                  end else begin
                     cmd.at_load    = 1'b1;
                     cmd.at_sel     = slle_pkg::AT_HEAD;
                     cmd.steps_load = 1'b1;
                     cmd.steps_sel  = slle_pkg::STEPS_POS;
                     state_in       = S_WALK;
                  end
               end
               slle_pkg::CMD_LOCATE: begin
                  cmd.link_rsel  = slle_pkg::LRA_HEAD;
                  cmd.steps_load = 1'b1;
                  cmd.steps_sel  = slle_pkg::STEPS_COUNT;
                  state_in       = S_LOC_NEXT;
               end
               default: begin
                  cmd.res_load   = 1'b1;
                  cmd.res_status = slle_pkg::ST_OK;
                  state_in       = S_DONE;
               end
            endcase
         end
         S_INS_FRESH: begin
            if (stat.rd_zero) begin
               cmd.res_load   = 1'b1;
               cmd.res_status = slle_pkg::ST_FULL;
               state_in       = S_DONE;
            end else begin
               cmd.node_load = 1'b1;
               cmd.val_we    = 1'b1;
               cmd.link_rsel = slle_pkg::LRA_RD;
               state_in      = S_INS_POP;
            end
         end
         S_INS_POP: begin
            cmd.link_we    = 1'b1;
            cmd.link_wsel  = slle_pkg::LWA_ZERO;
            cmd.link_dsel  = slle_pkg::LWD_RD;
            cmd.at_load    = 1'b1;
            cmd.at_sel     = slle_pkg::AT_HEAD;
            cmd.steps_load = 1'b1;
            cmd.steps_sel  = slle_pkg::STEPS_POS;
            state_in       = S_WALK;
         end
         S_WALK: begin
            cmd.link_rsel = slle_pkg::LRA_AT;
            if (stat.steps_zero) begin
               state_in = S_PRED;
            end else begin
               cmd.steps_dec = 1'b1;
               state_in      = S_WALK_STEP;
            end
         end
         S_WALK_STEP: begin
            cmd.at_load   = 1'b1;
            cmd.at_sel    = slle_pkg::AT_RD;
            cmd.link_rsel = slle_pkg::LRA_RD;
            if (stat.steps_zero) begin
               state_in = S_PRED;
            end else begin
               cmd.steps_dec = 1'b1;
            end
         end
         S_PRED: begin
            if (stat.cmd_code == slle_pkg::CMD_INSERT) begin
               cmd.link_we   = 1'b1;
               cmd.link_wsel = slle_pkg::LWA_NODE;
               cmd.link_dsel = slle_pkg::LWD_RD;
               state_in      = S_INS_LINK;
            end else begin
               cmd.node_load = 1'b1;
               cmd.link_rsel = slle_pkg::LRA_RD;
               state_in      = S_DEL_GONE;
            end
         end
         S_INS_LINK: begin
            cmd.link_we    = 1'b1;
            cmd.link_wsel  = slle_pkg::LWA_AT;
            cmd.link_dsel  = slle_pkg::LWD_NODE;
            cmd.count_inc  = 1'b1;
            cmd.res_load   = 1'b1;
            cmd.res_status = slle_pkg::ST_OK;
            state_in       = S_DONE;
         end
         S_DEL_GONE: begin
            cmd.link_we   = 1'b1;
            cmd.link_wsel = slle_pkg::LWA_AT;
            cmd.link_dsel = slle_pkg::LWD_RD;
            cmd.link_rsel = slle_pkg::LRA_ZERO;
            state_in      = S_DEL_FREE;
         end
         S_DEL_FREE: begin
            cmd.link_we   = 1'b1;
            cmd.link_wsel = slle_pkg::LWA_NODE;
            cmd.link_dsel = slle_pkg::LWD_RD;
            state_in      = S_DEL_PUSH;
         end
         S_DEL_PUSH: begin
            cmd.link_we    = 1'b1;
            cmd.link_wsel  = slle_pkg::LWA_ZERO;
            cmd.link_dsel  = slle_pkg::LWD_NODE;
            cmd.count_dec  = 1'b1;
            cmd.res_load   = 1'b1;
            cmd.res_status = slle_pkg::ST_OK;
            state_in       = S_DONE;
         end
         S_LOC_NEXT: begin
            if (stat.steps_zero || stat.rd_zero) begin
               cmd.res_load   = 1'b1;
               cmd.res_status = slle_pkg::ST_MISS;
               state_in       = S_DONE;
            end else begin
               cmd.at_load   = 1'b1;
               cmd.at_sel    = slle_pkg::AT_RD;
               cmd.link_rsel = slle_pkg::LRA_RD;
               state_in      = S_LOC_CMP;
            end
         end
         S_LOC_CMP: begin
            if (stat.val_match) begin
               cmd.res_load   = 1'b1;
               cmd.res_status = slle_pkg::ST_OK;
               cmd.res_found  = 1'b1;
               state_in       = S_DONE;
            end else if (stat.steps_one || stat.rd_zero) begin
               cmd.res_load   = 1'b1;
               cmd.res_status = slle_pkg::ST_MISS;
               state_in       = S_DONE;
            end else begin
               cmd.at_load   = 1'b1;
               cmd.at_sel    = slle_pkg::AT_RD;
               cmd.link_rsel = slle_pkg::LRA_RD;
               cmd.steps_dec = 1'b1;
            end
         end
         S_DONE: begin
            if (!stat.rsp_busy) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== design/static_linked_list_engine.sv =====
// static linked list engine: an array of NODES nodes holding a singly linked list
// plus a free chain (node 0 heads the free chain, node NODES-1 heads the list)
// req channel: one transaction per command (cmd, position, value) on valid/ready
//   insert places value before a 1-based position, delete removes one, locate
//   returns the node index of the first match, length reports the element count
// rsp channel: exactly one transaction per command (status, node_index, list_length)
// each list hop is one link ram read: insert and delete walk to the position,
//   locate walks the list until a match or the end of the list
// one command in flight; req_ready is high only in the idle state that follows
//   the result load, so a command is not taken before the previous one is done
// the next command may be accepted while the previous result still waits on rsp
// a stalled receiver holds the result in the output register; the engine finishes
// its work and then waits for the output register before taking the next command
// reset (synchronous, active high) clears the count and runs a link initialising
// pass over all NODES entries during which req_ready stays low
`default_nettype none

module static_linked_list_engine #(
   parameter int NODES = slle_pkg::NODES_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic [slle_pkg::CMD_W-1:0]        req_cmd,
   input  wire logic [slle_pkg::POS_W-1:0]        req_position,
   input  wire logic signed [slle_pkg::VAL_W-1:0] req_value,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic [slle_pkg::STATUS_W-1:0]          rsp_status,
   output logic [slle_pkg::IDX_OUT_W-1:0]         rsp_node_index,
   output logic [slle_pkg::LEN_W-1:0]             rsp_list_length
);

   // controller drives the datapath only through these two groups
   slle_pkg::ctrl_cmd_type  cmd;
   slle_pkg::dp_status_type stat;

   // sequencer: clearing pass, pointer walks, relinking, result hand-off
   slle_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // link and value rams, walk pointers, element count, output register
   slle_dp #(
      .NODES (NODES)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .req_cmd         (req_cmd),
      .req_position    (req_position),
      .req_value       (req_value),
      .cmd             (cmd),
      .stat            (stat),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_node_index  (rsp_node_index),
      .rsp_list_length (rsp_list_length)
   );

endmodule

`default_nettype wire

// ===== design/slle_checker.sv =====
`default_nettype none

module slle_checker #(
   parameter int NODES = slle_pkg::NODES_DEFAULT
) (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              req_valid,
   input wire logic                              req_ready,
   input wire logic                              rsp_valid,
   input wire logic                              rsp_ready,
   input wire logic [slle_pkg::STATUS_W-1:0]     rsp_status,
   input wire logic [slle_pkg::IDX_OUT_W-1:0]    rsp_node_index,
   input wire logic [slle_pkg::LEN_W-1:0]        rsp_list_length
);

   // a stalled result holds still
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_node_index) && $stable(rsp_list_length))
      else $error("stalled result changed");

   // one command at a time
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second command taken while one is in flight");

   // nothing comes out right after reset
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result shown after reset");

   // only a successful locate reports a node
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != slle_pkg::ST_OK) |-> (rsp_node_index == '0))
      else $error("node index on a failed command");

   // the list never holds more than NODES-2 elements
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (int'(rsp_list_length) <= NODES - 2))
      else $error("list length beyond capacity");

endmodule

bind static_linked_list_engine slle_checker #(
   .NODES (NODES)
) u_slle_chk (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_ready       (req_ready),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_status      (rsp_status),
   .rsp_node_index  (rsp_node_index),
   .rsp_list_length (rsp_list_length)
);

`default_nettype wire
